[hw/rtl/pfb_pkg.sv]
// Package for the page frame buffer: geometry constants, command codes,
// request and result types, controller states and control/status bundles.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pfb_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = 13;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [2:0] MODE_RD_BYTE = 3'd0;
  localparam logic [2:0] MODE_WR_BYTE = 3'd1;
  localparam logic [2:0] MODE_SET_PIX = 3'd2;
  localparam logic [2:0] MODE_GET_PIX = 3'd3;
  localparam logic [2:0] MODE_FILL    = 3'd4;
  localparam logic [2:0] MODE_ROTATE  = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] column;
    logic [6:0] row;
    logic [2:0] page;
    logic [7:0] data;
    logic       pixel_value;
  } pfb_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       pixel_bit;
    logic       out_of_range;
  } pfb_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_RESPOND,
    ST_FILL,
    ST_ROT_RD,
    ST_ROT_WLO,
    ST_ROT_WHI
  } pfb_state_t;

  typedef struct packed {
    logic load_req;
    logic ptr_init;
    logic step;
    logic rd;
    logic rot;
    logic wr_fill;
    logic zero_fill;
    logic wr_byte;
    logic wr_pix;
    logic wr_lo;
    logic wr_hi;
  } pfb_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       oor;
    logic       sweep_last;
    logic       rot_last;
  } pfb_stat_t;

endpackage

`default_nettype wire

[hw/rtl/pfb_datapath.sv]
// Datapath of the page frame buffer: request register, frame memory with
// one write and two registered read ports, sweep pointers and result logic.
// Depends on pfb_pkg; driven by pfb_ctrl through a command bundle.
`default_nettype none

module pfb_datapath (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire pfb_pkg::pfb_req_t  in_req,
  input  wire pfb_pkg::pfb_cmd_t  cmd,
  output pfb_pkg::pfb_stat_t      stat,
  output pfb_pkg::pfb_res_t       out_res
);
  import pfb_pkg::*;

  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return r;
  endfunction

  logic [7:0] mem [DEPTH];

  pfb_req_t   req_r;
  addr_t      ptr_lo_r, ptr_lo_nxt;
  addr_t      ptr_hi_r, ptr_hi_nxt;
  logic [7:0] rd_a_r;
  logic [7:0] rd_b_r;

  logic             col_ok, page_ok, row_ok, is_pix, oor;
  logic [3:0]       page_sel;
  logic [IDX_W-1:0] idx_wide;
  addr_t            idx;
  addr_t            raddr_a;
  logic [7:0]       mask;
  logic             we;
  addr_t            waddr;
  logic [7:0]       wdata;
  logic [ADDR_W:0]  lo_inc;

  assign col_ok  = {1'b0, req_r.column} < 9'(COLUMNS);
  assign page_ok = {2'b00, req_r.page} < 5'(PAGES);
  assign row_ok  = {1'b0, req_r.row} < 8'(ROWS);
  assign is_pix  = req_r.mode inside {MODE_SET_PIX, MODE_GET_PIX};

  always_comb begin
    if (req_r.mode inside {MODE_RD_BYTE, MODE_WR_BYTE}) begin
      oor = !(col_ok && page_ok);
    end else if (is_pix) begin
      oor = !(col_ok && row_ok);
    end else begin
      oor = 1'b0;
    end
  end

  // Pixel commands take the page from the upper row bits.
  assign page_sel = is_pix ? req_r.row[6:3] : {1'b0, req_r.page};
  assign idx_wide = IDX_W'(page_sel) * IDX_W'(COLUMNS) + IDX_W'(req_r.column);
  assign idx      = idx_wide[ADDR_W-1:0];
  assign mask     = 8'h01 << req_r.row[2:0];
  assign raddr_a  = cmd.rot ? ptr_lo_r : idx;

  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = req_r.data;
    if (cmd.wr_fill) begin
      waddr = ptr_lo_r;
      wdata = cmd.zero_fill ? 8'h00 : req_r.data;
    end else if (cmd.wr_byte) begin
      waddr = idx;
      wdata = req_r.data;
    end else if (cmd.wr_pix) begin
      waddr = idx;
      wdata = req_r.pixel_value ? (rd_a_r | mask) : (rd_a_r & ~mask);
    end else if (cmd.wr_lo) begin
      waddr = ptr_lo_r;
      wdata = bit_rev(rd_b_r);
    end else if (cmd.wr_hi) begin
      waddr = ptr_hi_r;
      wdata = bit_rev(rd_a_r);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[ptr_hi_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
  end

  always_comb begin
    ptr_lo_nxt = ptr_lo_r;
    ptr_hi_nxt = ptr_hi_r;
    if (cmd.ptr_init) begin
      ptr_lo_nxt = '0;
      ptr_hi_nxt = addr_t'(DEPTH - 1);
    end else if (cmd.step) begin
      ptr_lo_nxt = ptr_lo_r + addr_t'(1);
      ptr_hi_nxt = ptr_hi_r - addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_lo_r <= '0;
      ptr_hi_r <= addr_t'(DEPTH - 1);
    end else begin
      ptr_lo_r <= ptr_lo_nxt;
      ptr_hi_r <= ptr_hi_nxt;
    end
  end

  // The pair in hand is the last one once the next pair would cross over.
  assign lo_inc = {1'b0, ptr_lo_r} + {{ADDR_W{1'b0}}, 1'b1};

  assign stat.mode       = req_r.mode;
  assign stat.oor        = oor;
  assign stat.sweep_last = ptr_lo_r == addr_t'(DEPTH - 1);
  assign stat.rot_last   = lo_inc >= {1'b0, ptr_hi_r};

  assign out_res.read_byte    = (req_r.mode == MODE_RD_BYTE && !oor) ? rd_a_r : 8'h00;
  assign out_res.pixel_bit    = (req_r.mode == MODE_GET_PIX && !oor) ?
                                rd_a_r[req_r.row[2:0]] : 1'b0;
  assign out_res.out_of_range = oor;

`ifndef SYNTHESIS
  a_rot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd && cmd.rot) |-> (ptr_lo_r <= ptr_hi_r))
    else $error("rotate read with crossed pointers");
  a_pix_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pix |-> (!oor && req_r.mode == MODE_SET_PIX))
    else $error("pixel write off screen or for wrong command");
`endif

endmodule

`default_nettype wire

[hw/rtl/pfb_ctrl.sv]
// Controller state machine of the page frame buffer: sequences the reset
// clear, single accesses, fill sweep and rotate swap loop.
// Depends on pfb_pkg; drives pfb_datapath through a command bundle.
`default_nettype none

module pfb_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  output logic                    out_valid,
  input  wire pfb_pkg::pfb_stat_t stat,
  output pfb_pkg::pfb_cmd_t       cmd
);
  import pfb_pkg::*;

  pfb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE, ST_RESPOND: begin
        state_nxt = start ? ST_ACCESS : ST_IDLE;
      end
      ST_ACCESS: begin
        case (stat.mode)
          MODE_FILL:   state_nxt = ST_FILL;
          MODE_ROTATE: state_nxt = ST_ROT_RD;
          default:     state_nxt = ST_RESPOND;
        endcase
      end
      ST_FILL: begin
        if (stat.sweep_last) state_nxt = ST_RESPOND;
      end
      ST_ROT_RD:  state_nxt = ST_ROT_WLO;
      ST_ROT_WLO: state_nxt = ST_ROT_WHI;
      ST_ROT_WHI: begin
        state_nxt = stat.rot_last ? ST_RESPOND : ST_ROT_RD;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_fill   = 1'b1;
        cmd.zero_fill = 1'b1;
        cmd.step      = 1'b1;
      end
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.load_req = start;
        cmd.ptr_init = start;
      end
      ST_ACCESS: begin
        cmd.rd      = 1'b1;
        cmd.wr_byte = stat.mode == MODE_WR_BYTE && !stat.oor;
      end
      ST_RESPOND: begin
        // The pixel write-back lands at the same edge a new request loads.
        busy         = 1'b0;
        out_valid    = 1'b1;
        cmd.wr_pix   = stat.mode == MODE_SET_PIX && !stat.oor;
        cmd.load_req = start;
        cmd.ptr_init = start;
      end
      ST_FILL: begin
        cmd.wr_fill = 1'b1;
        cmd.step    = 1'b1;
      end
      ST_ROT_RD: begin
        cmd.rd  = 1'b1;
        cmd.rot = 1'b1;
      end
      ST_ROT_WLO: begin
        cmd.wr_lo = 1'b1;
      end
      ST_ROT_WHI: begin
        cmd.wr_hi = 1'b1;
        cmd.step  = !stat.rot_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy clearing after reset");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !cmd.wr_fill && !cmd.wr_lo && !cmd.wr_hi))
    else $error("result shown while a sweep is still running");
`endif

endmodule

`default_nettype wire

[hw/rtl/page_frame_buffer.sv]
// Top level of the page frame buffer: controller plus datapath.
// Depends on pfb_pkg, pfb_ctrl and pfb_datapath.
//
// Usage: present a request on in_req and raise start; it is taken at a
// rising edge where start is high and busy is low. Each request gives
// exactly one result on out_res, marked by out_valid for one cycle; the
// receiver must take it then, as there is no way to hold results off.
// Byte and pixel requests pass through an access state, which reads the
// frame memory (and for a byte write also writes it), and a result state,
// which shows the result and, for a pixel set or clear, writes back the
// modified byte. busy is low in the result cycle, so a new request can be
// taken while the result is shown. Fill writes one byte per cycle over the
// single write port. Rotate swaps the bytes one pair at a time in steps
// (read both, write low, write high). Unused modes return an all-zero
// result. After reset the block clears the frame memory to zero, one byte
// per cycle, with busy high; then it waits for start.
`default_nettype none

module page_frame_buffer (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire pfb_pkg::pfb_req_t in_req,
  output logic                   out_valid,
  output pfb_pkg::pfb_res_t      out_res
);
  import pfb_pkg::*;

  pfb_cmd_t  cmd;
  pfb_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfb_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule

`default_nettype wire
